// ===== rtl/fcd_pkg.sv =====
// Shared types, widths and constants of the force/torque decoupling block.
// Holds the decoupling coefficient table and the handshake structs.
// No dependencies.
package fcd_pkg;

    localparam int CHANNELS     = 6;
    localparam int CH_W         = 3;
    localparam int CNT_W        = 16;
    localparam int CFG_W        = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int OUT_W        = 24;
    localparam int STATUS_W     = 2;
    localparam int Q_W          = 37;
    localparam int V_W          = Q_W + 1;
    localparam int V_LO_W       = 19;
    localparam int NUM_W        = 54;
    localparam int DEN2_W       = 33;
    localparam int ACC_W        = 64;
    localparam int ROM_W        = 24;
    localparam int ROM_DEPTH    = CHANNELS * CHANNELS;
    localparam int ROM_ADDR_W   = 6;
    localparam int DIV_CNT_W    = 6;
    localparam int SCALE_SHIFT  = 25;
    localparam int ROUND_SHIFT  = 23;

    localparam logic [12:0] SCALE_MUL = 13'd5000;

    localparam logic [CFG_IDX_W-1:0] REG_OFFS_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFS_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HI = 3'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAT       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_GAIN = 2'd2;

    localparam logic [40:0] OUT_MAX_MAG = 41'd8388607;
    localparam logic [40:0] OUT_MIN_MAG = 41'd8388608;

    // Decoupling matrix, Q8.15, row = output, column = channel
    localparam logic signed [ROM_W-1:0] DEC_ROM [ROM_DEPTH] = '{
        -24'sd37317,   -24'sd14821,   -24'sd7011,   24'sd1475918, -24'sd47444, -24'sd1463350,
         24'sd35321,   -24'sd1677389,  24'sd18032,  24'sd843681,   24'sd43459,  24'sd853575,
         24'sd4617999,  24'sd59584,    24'sd4618711, 24'sd85988,   24'sd4663675, -24'sd34926,
        -24'sd2604,    -24'sd2253,    -24'sd58354,  -24'sd107,     24'sd58559,  24'sd1103,
         24'sd66578,    24'sd143,     -24'sd34741,  -24'sd2237,   -24'sd35786,  24'sd1604,
        -24'sd605,      24'sd22226,    24'sd130,     24'sd24036,   24'sd1225,   24'sd24589
    };

    typedef struct packed {
        logic            start;
        logic            fin;
        logic [CH_W-1:0] chan;
    } t_mac_cmd;

    typedef struct packed {
        logic                   busy;
        logic                   res_valid;
        logic [CH_W-1:0]        res_idx;
        logic signed [OUT_W-1:0] res_val;
        logic                   res_sat;
    } t_mac_stat;

    // Pick one 16-bit field out of a pair of packed registers
    function automatic logic [CNT_W-1:0] field16(input logic [CFG_W-1:0] lo3,
                                                 input logic [CFG_W-1:0] hi3,
                                                 input logic [CH_W-1:0]  ch);
        logic [CFG_W-1:0] w;
        begin
            w = (ch < 3'd3) ? lo3 : hi3;
            case (ch)
                3'd0, 3'd3: field16 = w[15:0];
                3'd1, 3'd4: field16 = w[31:16];
                3'd2, 3'd5: field16 = w[47:32];
                default:    field16 = w[15:0];
            endcase
        end
    endfunction

endpackage

// ===== rtl/fcd_if.sv =====
// Handshake interfaces of the decoupling block: sample, result, register write.
// Depends on fcd_pkg.
interface fcd_in_if import fcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_ch0;
    logic [CNT_W-1:0] count_ch1;
    logic [CNT_W-1:0] count_ch2;
    logic [CNT_W-1:0] count_ch3;
    logic [CNT_W-1:0] count_ch4;
    logic [CNT_W-1:0] count_ch5;
    modport source (output valid, count_ch0, count_ch1, count_ch2, count_ch3, count_ch4,
                    count_ch5, input ready);
    modport sink   (input valid, count_ch0, count_ch1, count_ch2, count_ch3, count_ch4,
                    count_ch5, output ready);
endinterface

interface fcd_out_if import fcd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic signed [OUT_W-1:0] torque_x;
    logic signed [OUT_W-1:0] torque_y;
    logic signed [OUT_W-1:0] torque_z;
    logic [STATUS_W-1:0]     status;
    modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    status, input ready);
    modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    status, output ready);
endinterface

interface fcd_cfg_if import fcd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fcd_div.sv =====
// Channel scaling: offset removal and rounded division by the gain term.
// Restoring divider, one quotient bit per cycle. Depends on fcd_pkg.
module fcd_div import fcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [CNT_W-1:0]      i_offset,
    input  logic [CNT_W-1:0]      i_gain,
    output logic                  o_done,
    output logic signed [V_W-1:0] o_v
);

    logic [CNT_W:0]        d;
    logic                  neg;
    logic [CNT_W-1:0]      mag;
    logic [28:0]           prod;
    logic [31:0]           den;
    logic [NUM_W-1:0]      num;
    logic [DEN2_W:0]       trial;
    logic                  ge;
    logic [DEN2_W:0]       diff;

    logic [DEN2_W-1:0]     r_rem;
    logic [Q_W-1:0]        r_quo;
    logic [DEN2_W-1:0]     r_den2;
    logic                  r_neg;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;

    always_comb begin
        d     = {1'b0, i_count} - {1'b0, i_offset};
        neg   = d[CNT_W];
        mag   = neg ? CNT_W'(-d) : d[CNT_W-1:0];
        prod  = 29'(mag) * 29'(SCALE_MUL);
        den   = {i_gain, 16'b0} - {16'b0, i_gain};
        num   = {prod, SCALE_SHIFT'(0)} + NUM_W'(den);
        trial = {r_rem, r_quo[Q_W-1]};
        ge    = trial >= {1'b0, r_den2};
        diff  = trial - {1'b0, r_den2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // preload the top numerator bits; they are below the divisor
                r_rem  <= DEN2_W'(num[NUM_W-1:Q_W]);
                r_quo  <= num[Q_W-1:0];
                r_den2 <= {den, 1'b0};
                r_neg  <= neg;
                r_cnt  <= DIV_CNT_W'(Q_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DEN2_W-1:0] : trial[DEN2_W-1:0];
                r_quo <= {r_quo[Q_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_v    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

// ===== rtl/fcd_mac.sv =====
// Decoupling matrix engine: coefficient ROM, accumulator memory, final rounding.
// Sweeps six rows per channel value; depends on fcd_pkg.
module fcd_mac import fcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mac_cmd              i_cmd,
    input  logic signed [V_W-1:0] i_v,
    output t_mac_stat             o_stat
);

    logic signed [ACC_W-1:0]      r_acc_mem [CHANNELS];

    logic signed [V_W-1:0]        r_v;
    logic                         r_busy;
    logic [CH_W-1:0]              r_cnt;
    logic [CH_W-1:0]              r_chan;
    logic                         r_fin;

    logic signed [ROM_W-1:0]      r_rom_q;
    logic signed [ACC_W-1:0]      r_acc_q;
    logic                         r_s1_vld;
    logic [CH_W-1:0]              r_s1_j;
    logic                         r_s1_first;
    logic                         r_s1_fin;

    logic signed [43:0]           r_p_lo;
    logic signed [42:0]           r_p_hi;
    logic signed [ACC_W-1:0]      r_acc2;
    logic                         r_s2_vld;
    logic [CH_W-1:0]              r_s2_j;
    logic                         r_s2_first;
    logic                         r_s2_fin;

    logic [ROM_ADDR_W-1:0]        rom_addr;
    logic signed [ACC_W-1:0]      base;
    logic signed [ACC_W-1:0]      sum;
    logic                         rnd_neg;
    logic [ACC_W-1:0]             rnd_mag;
    logic [ACC_W-1:0]             rnd_add;
    logic [40:0]                  rnd_r;
    logic                         rnd_sat;
    logic [OUT_W-1:0]             rnd_val;

    assign rom_addr = ROM_ADDR_W'({r_cnt, 2'b0}) + ROM_ADDR_W'({r_cnt, 1'b0})
                    + ROM_ADDR_W'(r_chan);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (i_cmd.start || i_cmd.fin) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_chan <= i_cmd.chan;
                r_fin  <= i_cmd.fin;
                if (i_cmd.start) begin
                    r_v <= i_v;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CH_W'(CHANNELS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            r_s1_vld <= r_busy;
            r_s2_vld <= r_s1_vld;
        end
    end

    // Read stage: coefficient and accumulator, both registered
    always_ff @(posedge i_clk) begin
        r_rom_q    <= DEC_ROM[rom_addr];
        r_acc_q    <= r_acc_mem[r_cnt];
        r_s1_j     <= r_cnt;
        r_s1_first <= (r_chan == '0);
        r_s1_fin   <= r_fin;
    end

    // Multiply stage: split the channel value into two narrow products
    always_ff @(posedge i_clk) begin
        r_p_lo     <= $signed({1'b0, r_v[V_LO_W-1:0]}) * r_rom_q;
        r_p_hi     <= $signed(r_v[V_W-1:V_LO_W]) * r_rom_q;
        r_acc2     <= r_acc_q;
        r_s2_j     <= r_s1_j;
        r_s2_first <= r_s1_first;
        r_s2_fin   <= r_s1_fin;
    end

    always_comb begin
        base    = r_s2_first ? '0 : r_acc2;
        sum     = base + (ACC_W'(r_p_hi) <<< V_LO_W) + ACC_W'(r_p_lo);
        rnd_neg = r_acc2[ACC_W-1];
        rnd_mag = rnd_neg ? ACC_W'(-r_acc2) : ACC_W'(r_acc2);
        rnd_add = rnd_mag + (ACC_W'(1) << (ROUND_SHIFT - 1));
        rnd_r   = rnd_add[ACC_W-1:ROUND_SHIFT];
        rnd_sat = 1'b0;
        if (rnd_neg) begin
            if (rnd_r > OUT_MIN_MAG) begin
                rnd_r   = OUT_MIN_MAG;
                rnd_sat = 1'b1;
            end
            rnd_val = OUT_W'(-rnd_r);
        end else begin
            if (rnd_r > OUT_MAX_MAG) begin
                rnd_r   = OUT_MAX_MAG;
                rnd_sat = 1'b1;
            end
            rnd_val = rnd_r[OUT_W-1:0];
        end
    end

    // Write-back stage
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && !r_s2_fin) begin
            r_acc_mem[r_s2_j] <= sum;
        end
    end

    assign o_stat.busy      = r_busy | r_s1_vld | r_s2_vld;
    assign o_stat.res_valid = r_s2_vld & r_s2_fin;
    assign o_stat.res_idx   = r_s2_j;
    assign o_stat.res_val   = $signed(rnd_val);
    assign o_stat.res_sat   = rnd_sat;

endmodule

// ===== rtl/force_torque_calibrate_decouple.sv =====
// Top level of the six-axis force/torque calibration and decoupling block.
// Depends on fcd_pkg, fcd_if, fcd_div and fcd_mac.
//
//   channel  | direction | carries
//   ---------+-----------+---------------------------------------------
//   i_in     | sink      | six raw 16-bit bridge counts per transfer
//   o_out    | source    | three forces, three torques (Q15.8), status
//   i_cfg    | sink      | register index and 48-bit write data
//
// Flow: each channel in turn passes through the shared restoring divider (one
// quotient bit per cycle, a 37-bit quotient per channel, plus load and hand-over),
// then the last row sweep drains and the accumulators are read out and rounded;
// a new item starts only after the previous result has left the staging buffer.
// A zero gain skips the divider and its result goes from the input register
// straight into the staging buffer. The divider sets the rate.
// Reset clears control state and registers; the accumulator memory needs no
// clearing, as channel 0 of each item overwrites it. A stalled output holds
// one result in the output register and one in the staging buffer, and one
// more sample waits in the input register.
module force_torque_calibrate_decouple import fcd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fcd_in_if.sink   i_in,
    fcd_out_if.source o_out,
    fcd_cfg_if.sink  i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_WAIT  = 5'b00100,
        S_LAST  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;

    logic [CFG_W-1:0]         r_offs_lo;
    logic [CFG_W-1:0]         r_offs_hi;
    logic [CFG_W-1:0]         r_gain_lo;
    logic [CFG_W-1:0]         r_gain_hi;

    logic                     r_in_full;
    logic [CNT_W-1:0]         r_in  [CHANNELS];
    logic [CNT_W-1:0]         r_work [CHANNELS];
    logic [CH_W-1:0]          r_ch;

    logic signed [OUT_W-1:0]  r_res_val [CHANNELS];
    logic [STATUS_W-1:0]      r_res_status;
    logic                     r_res_done;
    logic                     r_sat;

    logic signed [OUT_W-1:0]  r_out_val [CHANNELS];
    logic [STATUS_W-1:0]      r_out_status;
    logic                     r_out_valid;

    logic                     in_take;
    logic                     res_move;
    logic                     zero_gain;
    logic                     item_go;
    logic                     div_done;
    logic signed [V_W-1:0]    div_v;
    t_mac_cmd                 mac_cmd;
    t_mac_stat                mac_stat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_in_full;
    assign in_take     = i_in.valid & !r_in_full;
    assign res_move    = r_res_done & (!r_out_valid | o_out.ready);
    assign item_go     = (r_state == S_IDLE) & r_in_full & !r_res_done;

    always_comb begin
        zero_gain = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (field16(r_gain_lo, r_gain_hi, CH_W'(k)) == '0) begin
                zero_gain = 1'b1;
            end
        end
    end

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offs_lo <= '0;
            r_offs_hi <= '0;
            r_gain_lo <= 48'h0100_0100_0100;
            r_gain_hi <= 48'h0100_0100_0100;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OFFS_LO: r_offs_lo <= i_cfg.data;
                REG_OFFS_HI: r_offs_hi <= i_cfg.data;
                REG_GAIN_LO: r_gain_lo <= i_cfg.data;
                REG_GAIN_HI: r_gain_hi <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    fcd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_START),
        .i_count  (r_work[r_ch]),
        .i_offset (field16(r_offs_lo, r_offs_hi, r_ch)),
        .i_gain   (field16(r_gain_lo, r_gain_hi, r_ch)),
        .o_done   (div_done),
        .o_v      (div_v)
    );

    always_comb begin
        mac_cmd.start = (r_state == S_WAIT) & div_done;
        mac_cmd.fin   = (r_state == S_LAST) & !mac_stat.busy & !r_res_done;
        mac_cmd.chan  = r_ch;
    end

    fcd_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (mac_cmd),
        .i_v    (div_v),
        .o_stat (mac_stat)
    );

    // Sequencer: one channel at a time through the divider, then read-out
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (item_go && !zero_gain) n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT: begin
                if (div_done) begin
                    n_state = (r_ch == CH_W'(CHANNELS - 1)) ? S_LAST : S_START;
                end
            end
            S_LAST:  if (mac_cmd.fin) n_state = S_FIN;
            S_FIN: begin
                if (mac_stat.res_valid && mac_stat.res_idx == CH_W'(CHANNELS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_full   <= 1'b0;
            r_res_done  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            r_sat       <= 1'b0;
        end else begin
            r_state <= n_state;

            // input register: take a sample, release it once copied
            if (in_take) begin
                r_in_full <= 1'b1;
            end else if (item_go) begin
                r_in_full <= 1'b0;
            end

            if (item_go) begin
                r_ch <= '0;
                if (zero_gain) begin
                    r_res_done   <= 1'b1;
                    r_res_status <= STATUS_ZERO_GAIN;
                end
            end else if (r_state == S_WAIT && div_done) begin
                r_ch <= r_ch + 1'b1;
            end

            if (mac_cmd.fin) begin
                r_sat <= 1'b0;
            end else if (mac_stat.res_valid) begin
                r_sat <= r_sat | mac_stat.res_sat;
                if (mac_stat.res_idx == CH_W'(CHANNELS - 1)) begin
                    r_res_done   <= 1'b1;
                    r_res_status <= (r_sat | mac_stat.res_sat) ? STATUS_SAT : STATUS_OK;
                end
            end

            // advance staging buffer into the output register
            if (res_move) begin
                r_res_done  <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in[0] <= i_in.count_ch0;
            r_in[1] <= i_in.count_ch1;
            r_in[2] <= i_in.count_ch2;
            r_in[3] <= i_in.count_ch3;
            r_in[4] <= i_in.count_ch4;
            r_in[5] <= i_in.count_ch5;
        end
        if (item_go) begin
            r_work <= r_in;
            if (zero_gain) begin
                for (int k = 0; k < CHANNELS; k++) begin
                    r_res_val[k] <= '0;
                end
            end
        end
        if (mac_stat.res_valid) begin
            r_res_val[mac_stat.res_idx] <= mac_stat.res_val;
        end
        if (res_move) begin
            r_out_val    <= r_res_val;
            r_out_status <= r_res_status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.force_x  = r_out_val[0];
    assign o_out.force_y  = r_out_val[1];
    assign o_out.force_z  = r_out_val[2];
    assign o_out.torque_x = r_out_val[3];
    assign o_out.torque_y = r_out_val[4];
    assign o_out.torque_z = r_out_val[5];
    assign o_out.status   = r_out_status;

endmodule
